FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files, included by jitter_rms_max_tracker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on clk, ignored while rst_n is low.
`define JR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jrms assertion failed");
// Checked on clk, also during reset.
`define JR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("jrms assertion failed");
`else
`define JR_ASSERT(lbl, prop)
`define JR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hw/rtl/jrms_pkg.sv
// Shared widths, constants and helpers for the jitter RMS tracker.
package jrms_pkg;
  localparam int WINDOW_DEPTH = 100;
  localparam int NS_W   = 30;
  localparam int SEC_W  = 32;
  localparam int JIT_W  = NS_W + 1;
  localparam int SQ_W   = 2 * NS_W;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int POS_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = SQ_W + FILL_W;
  localparam logic [NS_W-1:0] NS_MAX     = NS_W'(999999999);
  localparam logic [NS_W:0]   NS_PER_SEC = (NS_W+1)'(1000000000);

  function automatic logic [NS_W-1:0] sat_ns(input logic [NS_W-1:0] v);
    sat_ns = (v > NS_MAX) ? NS_MAX : v;
  endfunction
endpackage

FILE: hw/rtl/jrms_sqmul.sv
// Bit-serial squarer: one multiplier bit per cycle, shift-add.
module jrms_sqmul import jrms_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NS_W-1:0] mag,
  output logic            done,
  output logic [SQ_W-1:0] sq
);
  localparam int CNT_W = $clog2(NS_W + 1);

  logic            busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NS_W-1:0] acc_r, lo_r, mcand_r;
  logic            done_r;
  logic [NS_W:0]   sum;

  assign sum = {1'b0, acc_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r   <= '0;
      lo_r    <= mag;
      mcand_r <= mag;
    end else if (busy_r) begin
      acc_r <= sum[NS_W:1];
      lo_r  <= {sum[0], lo_r[NS_W-1:1]};
    end
  end

  assign done = done_r;
  assign sq   = {acc_r, lo_r};
endmodule

FILE: hw/rtl/jrms_div.sv
// Restoring divider, one quotient bit per cycle, narrow remainder.
module jrms_div import jrms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [FILL_W-1:0] divisor,
  output logic              done,
  output logic [SQ_W-1:0]   quotient
);
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_r, done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FILL_W-1:0] rem_r, div_r;
  logic [SUM_W-1:0]  quo_r;
  logic [FILL_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? FILL_W'(trial - {1'b0, div_r}) : trial[FILL_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[SQ_W-1:0];
endmodule

FILE: hw/rtl/jrms_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module jrms_sqrt import jrms_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output logic            done,
  output logic [NS_W-1:0] root
);
  localparam int CNT_W = $clog2(NS_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SQ_W-1:0]  v_r;
  logic [NS_W-1:0]  rem_r, root_r;
  logic [NS_W+1:0]  trial, tst;
  logic             ge;

  assign trial = {rem_r, v_r[SQ_W-1:SQ_W-2]};
  assign tst   = {root_r, 2'b01};
  assign ge    = trial >= tst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  // remainder stays at most 2*root, so NS_W bits hold it until the last step
  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[SQ_W-3:0], 2'b00};
      rem_r  <= ge ? NS_W'(trial - tst) : trial[NS_W-1:0];
      root_r <= {root_r[NS_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

FILE: hw/rtl/jitter_rms_max_tracker.sv
// Jitter RMS and maximum tracker: one timestamp in, one statistics transaction out.
// Each timestamp passes through the gap and jitter steps, the bit-serial square, the
// bit-serial divide of the running sum of squares by the fill count (the longest loop)
// and the bit-serial square root. The first two stamps skip the arithmetic and go
// straight to the output. One timestamp is worked on at a time; a new one is taken
// while the previous result still waits on the output. Squares of the last
// WINDOW_DEPTH jitters sit in a local memory.
module jitter_rms_max_tracker import jrms_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // stamp_sec[31:0], stamp_nsec[61:32]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // jitter_ns[30:0], rms_ns[60:31], max_abs_ns[90:61],
                                    // max_gap_sec[122:91]
  output logic [0:0]    out_tuser,  // stats_valid[0]
  input  logic          cfg_wen,
  input  logic [NS_W-1:0] cfg_wdata // interval_ns
);
  `include "assert_macros.svh"

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_GAP  = 8'b00000010,
    ST_JIT  = 8'b00000100,
    ST_MAG  = 8'b00001000,
    ST_SQ   = 8'b00010000,
    ST_DIV  = 8'b00100000,
    ST_SQRT = 8'b01000000,
    ST_OUT  = 8'b10000000
  } state_t;

  state_t state_r;

  logic [NS_W-1:0]   interval_r;
  logic [SEC_W-1:0]  sec_r, prev_sec_r, gap_sec_r, max_sec_r;
  logic [NS_W-1:0]   nsec_r, prev_nsec_r, gap_nsec_r, max_abs_r;
  logic [1:0]        stamp_cnt_r;
  logic [JIT_W-1:0]  jit_r;
  logic [POS_W-1:0]  ring_pos_r;
  logic [FILL_W-1:0] ring_fill_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]   old_sq_r;
  logic [SQ_W-1:0]   ring_mem [WINDOW_DEPTH];

  logic              res_stats_r;
  logic [JIT_W-1:0]  res_jit_r;
  logic [NS_W-1:0]   res_rms_r;

  logic              out_tvalid_r;
  logic [127:0]      out_tdata_r;
  logic              out_stats_r;

  logic              in_acc, out_free;
  logic              nsec_ge;
  logic [NS_W:0]     gap_ns_wide;
  logic [NS_W-1:0]   mag;
  logic              sq_done, div_done, sqrt_done;
  logic [SQ_W-1:0]   sq, quo;
  logic [NS_W-1:0]   root;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign nsec_ge     = nsec_r >= prev_nsec_r;
  assign gap_ns_wide = {1'b0, nsec_r} + (nsec_ge ? '0 : NS_PER_SEC) - {1'b0, prev_nsec_r};
  assign mag         = jit_r[JIT_W-1] ? NS_W'(~jit_r + JIT_W'(1)) : jit_r[NS_W-1:0];
  assign sum_nxt     = sum_r + {{(SUM_W-SQ_W){1'b0}}, sq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
    end else if (cfg_wen) begin
      interval_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_sec_r   <= '0;
      prev_nsec_r  <= '0;
      stamp_cnt_r  <= '0;
      ring_pos_r   <= '0;
      ring_fill_r  <= '0;
      sum_r        <= '0;
      max_abs_r    <= '0;
      max_sec_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) state_r <= ST_GAP;
        end
        ST_GAP: begin
          prev_sec_r  <= sec_r;
          prev_nsec_r <= nsec_r;
          if (stamp_cnt_r < 2'd2) begin
            stamp_cnt_r <= stamp_cnt_r + 2'd1;
            state_r     <= ST_OUT;
          end else begin
            stamp_cnt_r <= 2'd3;
            state_r     <= ST_JIT;
          end
        end
        ST_JIT: state_r <= ST_MAG;
        ST_MAG: begin
          if (mag > max_abs_r) begin
            max_abs_r <= mag;
            max_sec_r <= gap_sec_r;
          end
          if (ring_fill_r >= FILL_W'(WINDOW_DEPTH)) begin
            sum_r <= sum_r - {{(SUM_W-SQ_W){1'b0}}, old_sq_r};
          end else begin
            ring_fill_r <= ring_fill_r + FILL_W'(1);
          end
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          if (sq_done) begin
            sum_r      <= sum_nxt;
            ring_pos_r <= (ring_pos_r == POS_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : ring_pos_r + POS_W'(1);
            state_r    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sqrt_done) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output holding register: loads a new transaction when empty or as the old one leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sec_r  <= in_tdata[31:0];
      nsec_r <= sat_ns(in_tdata[61:32]);
    end
    if (state_r == ST_GAP) begin
      gap_nsec_r  <= gap_ns_wide[NS_W-1:0];
      gap_sec_r   <= sec_r - prev_sec_r - (nsec_ge ? SEC_W'(0) : SEC_W'(1));
      res_stats_r <= 1'b0;
      res_jit_r   <= '0;
      res_rms_r   <= '0;
    end
    if (state_r == ST_JIT) begin
      jit_r    <= {1'b0, gap_nsec_r} - {1'b0, sat_ns(interval_r)};
      old_sq_r <= ring_mem[ring_pos_r];
    end
    if (state_r == ST_SQ && sq_done) begin
      ring_mem[ring_pos_r] <= sq;
    end
    if (state_r == ST_SQRT && sqrt_done) begin
      res_stats_r <= 1'b1;
      res_jit_r   <= jit_r;
      res_rms_r   <= root;
    end
    if (state_r == ST_OUT && out_free) begin
      out_stats_r <= res_stats_r;
      out_tdata_r <= {5'd0, max_sec_r, max_abs_r, res_rms_r, res_jit_r};
    end
  end

  jrms_sqmul u_sqmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_MAG),
    .mag   (mag),
    .done  (sq_done),
    .sq    (sq)
  );

  jrms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_SQ && sq_done),
    .dividend (sum_nxt),
    .divisor  (ring_fill_r),
    .done     (div_done),
    .quotient (quo)
  );

  jrms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DIV && div_done),
    .radicand (quo),
    .done     (sqrt_done),
    .root     (root)
  );

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_stats_r;

  `JR_ASSERT(a_fill_bound, ring_fill_r <= FILL_W'(WINDOW_DEPTH))
  `JR_ASSERT(a_empty_sum, (ring_fill_r == '0) |-> (sum_r == '0))
  `JR_ASSERT(a_accept_to_gap, in_acc |=> (state_r == ST_GAP))
endmodule
